FILE: design/qtas_pkg.sv
// Shared types, codes and helpers of the quadtree atlas slot allocator.
// No dependencies; every other design file imports this package.
`default_nettype none
package qtas_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_ATLAS_SIDE = 4096;
    localparam int DEF_TABLE_ENTRIES = 4096;

    localparam logic [2:0] STAT_SOLID   = 3'd0;
    localparam logic [2:0] STAT_HIT     = 3'd1;
    localparam logic [2:0] STAT_PLACED  = 3'd2;
    localparam logic [2:0] STAT_BIG     = 3'd3;
    localparam logic [2:0] STAT_NOSPACE = 3'd4;
    localparam logic [2:0] STAT_RESET   = 3'd5;

    localparam logic [1:0] KIND_SOLID  = 2'd0;
    localparam logic [1:0] KIND_OUTFIT = 2'd2;

    localparam logic [2:0] CLS_TOP = 3'd4;

    // Classified request as it travels from the front to the back.
    typedef struct packed {
        logic        action;
        logic        atlas;
        logic        solid;
        logic        too_big;
        logic        outfit;
        logic [2:0]  cls;
        logic [63:0] key;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] slot_x;
        logic [11:0] slot_y;
        logic [2:0]  size_class;
        logic        space_warning;
    } t_result;

    // One key table entry; entries below the fill count are valid.
    typedef struct packed {
        logic        outfit;
        logic [63:0] key;
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  cls;
    } t_entry;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOK  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_MISS  = 7'b0001000,
        S_SPLIT = 7'b0010000,
        S_POP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_bstate;

    function automatic logic [11:0] class_side(input logic [2:0] c);
        return 12'd32 << c;
    endfunction

endpackage
`default_nettype wire

FILE: design/quadtree_atlas_slot_allocator.sv
// Top level of the quadtree atlas slot allocator.
// Depends on qtas_pkg, qtas_front and qtas_back.
//
// Usage:
//  - Input channel (i_valid / o_ready) takes one request: a place request or
//    an atlas reset. Output channel (o_valid / i_ready) returns exactly one
//    result per request, in order.
//  - The front classifies a request (size class, too big, solid) in the
//    cycle it is accepted and queues it (two entries). The back then works
//    on one item at a time.
//  - Steps per item: solid, too big and reset go from accept straight to
//    the result. A place request first searches the stored keys of that
//    atlas (the key table is searched linearly, one memory read and one
//    compare per entry), then checks space, splits one level at a time
//    (up to 4 levels), and pops the slot and writes the table.
//  - The key table is a single-port-read memory; its fill count, not a
//    clearing pass, empties it, so a reset action takes effect at once.
//  - Reset (i_rst_n low) puts both atlases in the state left by a reset
//    action: 512 grid refilled, origin 32 slot reserved, table empty.
//  - When the receiver stalls, hold the result in the output register;
//    the queue keeps accepting until it is full.
`default_nettype none
module quadtree_atlas_slot_allocator #(
    parameter int ATLAS_SIDE    = qtas_pkg::DEF_ATLAS_SIDE,
    parameter int TABLE_ENTRIES = qtas_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic        i_atlas_select,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_key,
    input  wire logic [15:0] i_width,
    input  wire logic [15:0] i_height,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [11:0]      o_slot_x,
    output logic [11:0]      o_slot_y,
    output logic [2:0]       o_size_class,
    output logic             o_space_warning
);
    import qtas_pkg::*;

    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    t_result res;

    qtas_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_atlas_select (i_atlas_select),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_width        (i_width),
        .i_height       (i_height),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    qtas_back #(
        .ATLAS_SIDE    (ATLAS_SIDE),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_res     (res),
        .i_ready   (i_ready)
    );

    // Unpack the result register onto the output fields.
    assign o_status        = res.status;
    assign o_slot_x        = res.slot_x;
    assign o_slot_y        = res.slot_y;
    assign o_size_class    = res.size_class;
    assign o_space_warning = res.space_warning;

endmodule
`default_nettype wire

FILE: design/qtas_front.sv
// Front part: classifies requests and holds them in a short queue.
// Depends on qtas_pkg.
`default_nettype none
module qtas_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic           i_action,
    input  wire logic           i_atlas_select,
    input  wire logic [1:0]     i_kind,
    input  wire logic [63:0]    i_key,
    input  wire logic [15:0]    i_width,
    input  wire logic [15:0]    i_height,
    output logic                o_q_valid,
    output qtas_pkg::t_item     o_q_item,
    input  wire logic           i_q_pop
);
    import qtas_pkg::*;

    logic [15:0] size;
    t_item       item;
    t_item       r_q [0:QUEUE_DEPTH-1];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        push;

    // Round the larger side up to a size class.
    always_comb begin
        size = (i_width > i_height) ? i_width : i_height;
        item.action  = i_action;
        item.atlas   = i_atlas_select;
        item.solid   = (i_kind == KIND_SOLID);
        item.outfit  = (i_kind == KIND_OUTFIT);
        item.key     = i_key;
        item.too_big = (size > 16'd512);
        if (size > 16'd256)      item.cls = 3'd4;
        else if (size > 16'd128) item.cls = 3'd3;
        else if (size > 16'd64)  item.cls = 3'd2;
        else if (size > 16'd32)  item.cls = 3'd1;
        else                     item.cls = 3'd0;
    end

    assign o_ready   = (r_count != 2'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push)    r_wptr <= ~r_wptr;
            if (i_q_pop) r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule
`default_nettype wire

FILE: design/qtas_back.sv
// Back part: key table search, slot splitting and popping, result register.
// Depends on qtas_pkg.
`default_nettype none
module qtas_back #(
    parameter int ATLAS_SIDE    = qtas_pkg::DEF_ATLAS_SIDE,
    parameter int TABLE_ENTRIES = qtas_pkg::DEF_TABLE_ENTRIES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire qtas_pkg::t_item i_q_item,
    output logic                o_q_pop,
    output logic                o_valid,
    output qtas_pkg::t_result   o_res,
    input  wire logic           i_ready
);
    import qtas_pkg::*;

    localparam int GRID_RAW  = ATLAS_SIDE / 512;
    localparam int GRID      = (GRID_RAW > 8) ? 8 : ((GRID_RAW < 1) ? 1 : GRID_RAW);
    localparam logic [2:0] GRID_LAST = 3'(GRID - 1);
    localparam logic [2:0] GX0 = (GRID == 1) ? 3'd1 : 3'd0;
    localparam logic [2:0] GY0 = (GRID == 1) ? 3'd0 : 3'd1;
    localparam logic [6:0] TOP_RST = 7'(GRID * GRID - 1);
    localparam int TI_W      = $clog2(TABLE_ENTRIES);
    localparam int U_W       = TI_W + 1;
    localparam int MEM_DEPTH = 2 << TI_W;
    localparam logic [U_W-1:0] TE_U = U_W'(TABLE_ENTRIES);

    t_bstate        r_state, n_state;
    t_item          r_item;
    logic [TI_W-1:0] r_idx;
    logic [2:0]     r_lvl;
    t_result        r_res;
    t_result        r_out;
    logic           r_out_valid;

    logic [U_W-1:0] r_used   [0:1];
    logic [6:0]     r_top_cnt[0:1];
    logic [2:0]     r_gx     [0:1];
    logic [2:0]     r_gy     [0:1];
    logic [2:0]     r_cnt    [0:1][0:3];
    logic [11:0]    r_px     [0:1][0:3];
    logic [11:0]    r_py     [0:1][0:3];

    t_entry         r_mem [0:MEM_DEPTH-1];
    t_entry         r_rd;

    logic           a;
    logic [U_W-1:0] used_a;
    logic           full;
    logic           found;
    logic [2:0]     lvl_sel;
    logic [2:0]     src;
    logic [2:0]     src_cnt;
    logic [1:0]     k;
    logic [11:0]    side;
    logic [11:0]    pop_x, pop_y;
    logic           hit;
    logic           last;
    logic           out_free;
    logic           mem_we;

    assign a        = r_item.atlas;
    assign used_a   = r_used[a];
    assign full     = (used_a >= TE_U);
    assign hit      = (r_rd.outfit == r_item.outfit) && (r_rd.key == r_item.key);
    assign last     = ((U_W'(r_idx) + 1'b1) == used_a);
    assign out_free = !r_out_valid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign mem_we   = (r_state == S_POP);
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // Smallest level at or above the requested class that has a free slot.
    always_comb begin
        found   = 1'b0;
        lvl_sel = CLS_TOP;
        for (int c = 0; c < 4; c++) begin
            if (!found && 3'(c) >= r_item.cls && r_cnt[a][c] != 3'd0) begin
                found   = 1'b1;
                lvl_sel = 3'(c);
            end
        end
        if (!found && r_top_cnt[a] != 7'd0) begin
            found   = 1'b1;
            lvl_sel = CLS_TOP;
        end
    end

    // Corner taken from the source level; a ring of four pops in push order.
    always_comb begin
        src     = (r_state == S_POP) ? r_item.cls : r_lvl;
        src_cnt = r_cnt[a][src[1:0]];
        k       = ~src_cnt[1:0] + 2'd1;
        side    = class_side(src);
        if (src == CLS_TOP) begin
            pop_x = {r_gx[a], 9'd0};
            pop_y = {r_gy[a], 9'd0};
        end else begin
            pop_x = r_px[a][src[1:0]] + (k[1] ? side : 12'd0);
            pop_y = r_py[a][src[1:0]] + (k[0] ? side : 12'd0);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.action || i_q_item.solid || i_q_item.too_big) begin
                        n_state = S_DONE;
                    end else if (r_used[i_q_item.atlas] == '0) begin
                        n_state = S_MISS;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK:  n_state = S_CMP;
            S_CMP:   n_state = hit ? S_DONE : (last ? S_MISS : S_LOOK);
            S_MISS: begin
                if (full || !found)            n_state = S_DONE;
                else if (lvl_sel == r_item.cls) n_state = S_POP;
                else                           n_state = S_SPLIT;
            end
            S_SPLIT: n_state = ((r_lvl - 3'd1) == r_item.cls) ? S_POP : S_SPLIT;
            S_POP:   n_state = S_DONE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Key table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[{a, used_a[TI_W-1:0]}] <= '{outfit: r_item.outfit, key: r_item.key,
                                             x: pop_x, y: pop_y, cls: r_item.cls};
        end
        r_rd <= r_mem[{a, r_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int t = 0; t < 2; t++) begin
                r_used[t]    <= '0;
                r_top_cnt[t] <= TOP_RST;
                r_gx[t]      <= GX0;
                r_gy[t]      <= GY0;
                for (int c = 0; c < 4; c++) begin
                    r_cnt[t][c] <= 3'd3;
                    r_px[t][c]  <= 12'd0;
                    r_py[t][c]  <= 12'd0;
                end
            end
        end else begin
            r_state <= n_state;
            // Load a new result when the register is free, else drop an accepted one.
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        r_idx  <= '0;
                        if (i_q_item.action) begin
                            // Refill the 512 grid, empty the table, reserve origin.
                            r_res <= '{status: STAT_RESET, slot_x: 12'd0, slot_y: 12'd0,
                                       size_class: 3'd0, space_warning: 1'b0};
                            r_used[i_q_item.atlas]        <= '0;
                            r_top_cnt[i_q_item.atlas]     <= TOP_RST;
                            r_gx[i_q_item.atlas]          <= GX0;
                            r_gy[i_q_item.atlas]          <= GY0;
                            for (int c = 0; c < 4; c++) begin
                                r_cnt[i_q_item.atlas][c] <= 3'd3;
                                r_px[i_q_item.atlas][c]  <= 12'd0;
                                r_py[i_q_item.atlas][c]  <= 12'd0;
                            end
                        end else if (i_q_item.solid) begin
                            r_res <= '{status: STAT_SOLID, slot_x: 12'd0, slot_y: 12'd0,
                                       size_class: 3'd0, space_warning: 1'b0};
                        end else if (i_q_item.too_big) begin
                            r_res <= '{status: STAT_BIG, slot_x: 12'd0, slot_y: 12'd0,
                                       size_class: 3'd0, space_warning: 1'b1};
                        end else begin
                            r_res <= '0;
                        end
                    end
                end
                S_CMP: begin
                    if (hit) begin
                        r_res <= '{status: STAT_HIT, slot_x: r_rd.x, slot_y: r_rd.y,
                                   size_class: r_rd.cls, space_warning: 1'b0};
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_MISS: begin
                    r_lvl <= lvl_sel;
                    if (full || !found) begin
                        r_res <= '{status: STAT_NOSPACE, slot_x: 12'd0, slot_y: 12'd0,
                                   size_class: r_item.cls, space_warning: r_item.outfit};
                    end
                end
                S_SPLIT, S_POP: begin
                    // Take the corner at the source level.
                    if (src == CLS_TOP) begin
                        r_top_cnt[a] <= r_top_cnt[a] - 7'd1;
                        if (r_gy[a] == GRID_LAST) begin
                            r_gy[a] <= 3'd0;
                            r_gx[a] <= r_gx[a] + 3'd1;
                        end else begin
                            r_gy[a] <= r_gy[a] + 3'd1;
                        end
                    end else begin
                        r_cnt[a][src[1:0]] <= src_cnt - 3'd1;
                    end
                    if (r_state == S_SPLIT) begin
                        // Refill the level below with four corners.
                        r_px[a][2'(r_lvl - 3'd1)]  <= pop_x;
                        r_py[a][2'(r_lvl - 3'd1)]  <= pop_y;
                        r_cnt[a][2'(r_lvl - 3'd1)] <= 3'd4;
                        r_lvl <= r_lvl - 3'd1;
                    end else begin
                        r_used[a] <= used_a + 1'b1;
                        r_res <= '{status: STAT_PLACED, slot_x: pop_x, slot_y: pop_y,
                                   size_class: r_item.cls, space_warning: 1'b0};
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= r_res;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/qtas_checker.sv
// Port-level checks of the quadtree atlas slot allocator, bound to the top.
// Depends on qtas_pkg and quadtree_atlas_slot_allocator.
`default_nettype none
module qtas_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_status,
    input wire logic [11:0] o_slot_x,
    input wire logic [11:0] o_slot_y,
    input wire logic [2:0]  o_size_class,
    input wire logic        o_space_warning
);
    import qtas_pkg::*;

    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_slot_x)
            && $stable(o_slot_y))
        else $error("stalled result changed");

    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_SOLID || o_status == STAT_RESET
            || o_status == STAT_BIG || o_status == STAT_NOSPACE)
        |-> o_slot_x == 12'd0 && o_slot_y == 12'd0)
        else $error("slot corner set on a result without a slot");

    a_warning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_space_warning |-> o_status == STAT_BIG || o_status == STAT_NOSPACE)
        else $error("space warning on a successful result");

    a_placed_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STAT_PLACED || o_status == STAT_HIT)
        |-> o_slot_x[4:0] == 5'd0 && o_slot_y[4:0] == 5'd0 && o_size_class <= CLS_TOP)
        else $error("slot corner off the 32 pixel grid");

endmodule

bind quadtree_atlas_slot_allocator qtas_checker u_qtas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_status        (o_status),
    .o_slot_x        (o_slot_x),
    .o_slot_y        (o_slot_y),
    .o_size_class    (o_size_class),
    .o_space_warning (o_space_warning)
);
`default_nettype wire
